// File: rtl/qots_pkg.sv
`default_nettype none

package qots_pkg;

  // default coordinate width
  localparam int unsigned COORD_WIDTH = 16;

  // path command codes
  typedef enum logic [1:0] {
    CMD_MOVE  = 2'd0,
    CMD_LINE  = 2'd1,
    CMD_CURVE = 2'd2,
    CMD_CLOSE = 2'd3
  } cmd_e;

  // how many points of the current contour are held
  typedef enum logic [1:0] {
    SEEN_NONE = 2'd0,
    SEEN_ONE  = 2'd1,
    SEEN_TWO  = 2'd2
  } seen_e;

endpackage

`default_nettype wire

// File: rtl/quadratic_outline_to_segments.sv
`default_nettype none

// channel  | handshake                  | beat fields
// ---------+----------------------------+------------------------------------------
// in       | in_valid_i / in_stall_o    | point_x_i point_y_i on_curve_i contour_end_i
// out      | out_valid_o / out_stall_i  | command_o ctrl_x_o ctrl_y_o dest_x_o dest_y_o
//          |                            | last_of_run_o
//
// a point passes an input register, a burst register and an output register.
// one point per cycle while out_stall_i is low and each point gives at most one command;
// a point giving n commands holds the burst register until all n are sent, one command
// per cycle while out_stall_i is low.
// reset clears the contour state and all valids.
// out_stall_i holds the output register and backs up through the burst to in_stall_o.

module quadratic_outline_to_segments #(
  parameter int unsigned COORD_WIDTH = qots_pkg::COORD_WIDTH
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire logic signed [COORD_WIDTH-1:0] point_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] point_y_i,
  input  wire logic                          on_curve_i,
  input  wire logic                          contour_end_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      logic [1:0]                    command_o,
  output      logic signed [COORD_WIDTH-1:0] ctrl_x_o,
  output      logic signed [COORD_WIDTH-1:0] ctrl_y_o,
  output      logic signed [COORD_WIDTH-1:0] dest_x_o,
  output      logic signed [COORD_WIDTH-1:0] dest_y_o,
  output      logic                          last_of_run_o
);

  localparam int unsigned W = COORD_WIDTH;

  typedef struct packed {
    logic                vld;
    qots_pkg::cmd_e      cmd;
    logic signed [W-1:0] cx;
    logic signed [W-1:0] cy;
    logic signed [W-1:0] dx;
    logic signed [W-1:0] dy;
    logic                last;
  } res_t;

  logic                in_vld_q;
  logic signed [W-1:0] px_q;
  logic signed [W-1:0] py_q;
  logic                on_q;
  logic                end_q;
  logic                accept;
  logic                xfer;
  logic                burst_rdy;
  logic [3:0][W*4+3:0] slot;
  logic [W*4+3:0]      out_raw;
  res_t                out_r;

  // input register
  assign xfer       = in_vld_q && burst_rdy;
  assign in_stall_o = in_vld_q && !burst_rdy;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (xfer) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q  <= point_x_i;
      py_q  <= point_y_i;
      on_q  <= on_curve_i;
      end_q <= contour_end_i;
    end
  end

  // command formation and contour state
  qots_build #(
    .W (W)
  ) u_build (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .xfer_i        (xfer),
    .point_x_i     (px_q),
    .point_y_i     (py_q),
    .on_curve_i    (on_q),
    .contour_end_i (end_q),
    .slot_o        (slot)
  );

  // burst serializer and output register
  qots_queue #(
    .W (W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (xfer),
    .slot_i      (slot),
    .rdy_o       (burst_rdy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_raw)
  );

  assign out_r         = out_raw;
  assign command_o     = out_r.cmd;
  assign ctrl_x_o      = out_r.cx;
  assign ctrl_y_o      = out_r.cy;
  assign dest_x_o      = out_r.dx;
  assign dest_y_o      = out_r.dy;
  assign last_of_run_o = out_r.last;

endmodule

`default_nettype wire

// File: rtl/qots_build.sv
`default_nettype none

module qots_build #(
  parameter int unsigned W = qots_pkg::COORD_WIDTH
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                xfer_i,
  input  wire logic signed [W-1:0] point_x_i,
  input  wire logic signed [W-1:0] point_y_i,
  input  wire logic                on_curve_i,
  input  wire logic                contour_end_i,
  output      logic [3:0][W*4+3:0] slot_o
);

  typedef struct packed {
    logic signed [W-1:0] x;
    logic signed [W-1:0] y;
    logic                on;
  } pt_t;

  typedef struct packed {
    logic                vld;
    qots_pkg::cmd_e      cmd;
    logic signed [W-1:0] cx;
    logic signed [W-1:0] cy;
    logic signed [W-1:0] dx;
    logic signed [W-1:0] dy;
    logic                last;
  } res_t;

  // midpoint, truncated toward zero
  function automatic logic signed [W-1:0] half(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic signed [W:0] s;
    logic signed [W:0] t;
    s = {a[W-1], a} + {b[W-1], b};
    t = s + $signed({{W{1'b0}}, s[W]});
    half = t[W:1];
  endfunction

  function automatic res_t mv(input pt_t p);
    res_t r;
    r     = '0;
    r.vld = 1'b1;
    r.cmd = qots_pkg::CMD_MOVE;
    r.dx  = p.x;
    r.dy  = p.y;
    mv    = r;
  endfunction

  function automatic res_t mid(input pt_t a, input pt_t b);
    res_t r;
    r = '0;
    if (!a.on && !b.on) begin
      r.vld = 1'b1;
      r.cmd = qots_pkg::CMD_MOVE;
      r.dx  = half(a.x, b.x);
      r.dy  = half(a.y, b.y);
    end
    mid = r;
  endfunction

  // command of point a looking ahead to b and c
  function automatic res_t seg(input pt_t a, input pt_t b, input pt_t c);
    res_t r;
    r = '0;
    if (a.on || !b.on) begin
      r.vld = 1'b1;
      if (b.on) begin
        r.cmd = qots_pkg::CMD_LINE;
        r.dx  = b.x;
        r.dy  = b.y;
      end else begin
        r.cmd = qots_pkg::CMD_CURVE;
        r.cx  = b.x;
        r.cy  = b.y;
        if (c.on) begin
          r.dx = c.x;
          r.dy = c.y;
        end else begin
          r.dx = half(b.x, c.x);
          r.dy = half(b.y, c.y);
        end
      end
    end
    seg = r;
  endfunction

  function automatic res_t cls();
    res_t r;
    r     = '0;
    r.vld = 1'b1;
    r.cmd = qots_pkg::CMD_CLOSE;
    cls   = r;
  endfunction

  pt_t            p;
  pt_t            first_q, first_d;
  pt_t            second_q, second_d;
  pt_t            older_q, older_d;
  pt_t            newer_q, newer_d;
  qots_pkg::seen_e seen_q, seen_d;
  res_t [3:0]     slot;
  logic           later;

  assign p = '{x: point_x_i, y: point_y_i, on: on_curve_i};

  // commands caused by the point
  always_comb begin
    slot = '0;
    unique case (seen_q)
      qots_pkg::SEEN_NONE: begin
        slot[0] = mv(p);
        if (contour_end_i) begin
          slot[1] = mid(p, p);
          slot[2] = seg(p, p, p);
          slot[3] = cls();
        end
      end
      qots_pkg::SEEN_ONE: begin
        slot[0] = mid(first_q, p);
        if (contour_end_i) begin
          slot[1] = seg(first_q, p, first_q);
          slot[2] = seg(p, first_q, p);
          slot[3] = cls();
        end
      end
      qots_pkg::SEEN_TWO: begin
        slot[0] = seg(older_q, newer_q, p);
        if (contour_end_i) begin
          slot[1] = seg(newer_q, p, first_q);
          slot[2] = seg(p, first_q, second_q);
          slot[3] = cls();
        end
      end
      default: begin
        slot = '0;
      end
    endcase
    // flag the final command of the beat
    later = 1'b0;
    for (int i = 3; i >= 0; i--) begin
      slot[i].last = slot[i].vld && !later;
      later        = later || slot[i].vld;
    end
  end

  assign slot_o = slot;

  // contour state update
  always_comb begin
    first_d  = first_q;
    second_d = second_q;
    older_d  = older_q;
    newer_d  = newer_q;
    seen_d   = seen_q;
    if (xfer_i) begin
      unique case (seen_q)
        qots_pkg::SEEN_NONE: begin
          first_d = p;
          if (!contour_end_i) begin
            seen_d = qots_pkg::SEEN_ONE;
          end
        end
        qots_pkg::SEEN_ONE: begin
          second_d = p;
          if (contour_end_i) begin
            seen_d = qots_pkg::SEEN_NONE;
          end else begin
            older_d = first_q;
            newer_d = p;
            seen_d  = qots_pkg::SEEN_TWO;
          end
        end
        qots_pkg::SEEN_TWO: begin
          if (contour_end_i) begin
            seen_d = qots_pkg::SEEN_NONE;
          end
          older_d = newer_q;
          newer_d = p;
        end
        default: begin
          seen_d = qots_pkg::SEEN_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= '0;
      second_q <= '0;
      older_q  <= '0;
      newer_q  <= '0;
      seen_q   <= qots_pkg::SEEN_NONE;
    end else begin
      first_q  <= first_d;
      second_q <= second_d;
      older_q  <= older_d;
      newer_q  <= newer_d;
      seen_q   <= seen_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/qots_queue.sv
`default_nettype none

module qots_queue #(
  parameter int unsigned W = qots_pkg::COORD_WIDTH
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                load_i,
  input  wire logic [3:0][W*4+3:0] slot_i,
  output      logic                rdy_o,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      logic [W*4+3:0]      out_o
);

  typedef struct packed {
    logic                vld;
    qots_pkg::cmd_e      cmd;
    logic signed [W-1:0] cx;
    logic signed [W-1:0] cy;
    logic signed [W-1:0] dx;
    logic signed [W-1:0] dy;
    logic                last;
  } res_t;

  res_t [3:0] slot_in;
  res_t [3:0] slot_q;
  logic [3:0] mask_q, mask_d;
  logic [3:0] low;
  logic [3:0] rem;
  logic       take;
  res_t       pick;
  res_t       out_q;
  logic       out_vld_q;

  assign slot_in = slot_i;

  // output register frees when empty or taken
  assign take = !out_vld_q || !out_stall_i;

  // lowest pending command of the burst
  assign low = mask_q & (~mask_q + 4'd1);
  assign rem = take ? (mask_q & ~low) : mask_q;
  assign rdy_o = (rem == 4'd0);

  always_comb begin
    pick = '0;
    for (int i = 0; i < 4; i++) begin
      if (low[i]) begin
        pick = slot_q[i];
      end
    end
  end

  always_comb begin
    mask_d = rem;
    if (load_i) begin
      for (int i = 0; i < 4; i++) begin
        mask_d[i] = slot_in[i].vld;
      end
    end
  end

  // burst holding register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot_q <= slot_in;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (take) begin
      out_vld_q <= (mask_q != 4'd0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && (mask_q != 4'd0)) begin
      out_q <= pick;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire
